// ===== design/asfa_pkg.sv =====
// Shared types and constants for the array sum point/fill unit.
package asfa_pkg;

	localparam int unsigned SUM_W   = 42;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned EPOCH_W = 8;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	typedef enum logic {
		OP_POINT = 1'b0,
		OP_FILL  = 1'b1
	} op_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic fill;
	} store_cmd_t;

endpackage

// ===== design/array_sum_point_and_fill_assign_unit.sv =====
// Top level: running sum of an array under point writes and fills.
// Path: the entry memory read and the item are registered into the update stage, whose
// result is registered into total_sum and out_valid.
// Flow: no item is accepted while one is in the update stage or a result waits for out_ready.
// Reset: sum and fill value clear to zero, count to 1024; the entry memory is swept after
// reset and again after every 255th fill (epoch tag wrap), with in_ready low.
module array_sum_point_and_fill_assign_unit #(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              element_count_we,
	input  logic [asfa_pkg::COUNT_W-1:0]      element_count_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [$clog2(DEPTH)-1:0]          entry_index,
	input  logic [VALUE_BITS-1:0]             value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [asfa_pkg::SUM_W-1:0]        total_sum,
	output logic                              index_error
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned EW    = (CNT_W > asfa_pkg::COUNT_W) ? CNT_W : asfa_pkg::COUNT_W;
	localparam int unsigned AW    = (VALUE_BITS > asfa_pkg::SUM_W) ? VALUE_BITS
	                                                              : asfa_pkg::SUM_W;
	localparam int unsigned PW    = VALUE_BITS + EW;

	logic [asfa_pkg::COUNT_W-1:0] count_q;
	logic [VALUE_BITS-1:0]        fill_value_q;
	logic [asfa_pkg::SUM_W-1:0]   sum_q;
	logic                         err_q;
	logic                         out_valid_q;

	logic                         s1_valid_s1;
	asfa_pkg::op_t                op_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [VALUE_BITS-1:0]        val_s1;
	logic                         err_s1;

	asfa_pkg::store_cmd_t         cmd;
	logic [VALUE_BITS-1:0]        rd_data;
	logic                         rd_fresh;
	logic                         store_busy;

	logic                         accept;
	logic [EW-1:0]                eff_count;
	logic [EW-1:0]                count_ext;
	logic [VALUE_BITS-1:0]        old_val;
	logic [AW-1:0]                point_sum;
	logic [PW-1:0]                fill_prod;
	logic [asfa_pkg::SUM_W-1:0]   next_sum;

	assign in_ready = !s1_valid_s1 && !store_busy && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign count_ext = EW'(count_q);
	assign eff_count = (count_ext > EW'(DEPTH)) ? EW'(DEPTH) : count_ext;

	assign cmd.rd_en = accept;
	assign cmd.wr_en = s1_valid_s1 && (op_s1 == asfa_pkg::OP_POINT) && !err_s1;
	assign cmd.fill  = s1_valid_s1 && (op_s1 == asfa_pkg::OP_FILL);

	asfa_store #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_addr  (entry_index),
		.wr_addr  (idx_s1),
		.wr_data  (val_s1),
		.rd_data  (rd_data),
		.rd_fresh (rd_fresh),
		.busy     (store_busy)
	);

	assign old_val   = rd_fresh ? rd_data : fill_value_q;
	assign point_sum = AW'(sum_q) - AW'(old_val) + AW'(val_s1);
	assign fill_prod = PW'(val_s1) * PW'(eff_count);

	always_comb begin
		case (op_s1)
			asfa_pkg::OP_FILL:  next_sum = fill_prod[asfa_pkg::SUM_W-1:0];
			asfa_pkg::OP_POINT: next_sum = err_s1 ? sum_q : point_sum[asfa_pkg::SUM_W-1:0];
			default:            next_sum = sum_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= asfa_pkg::op_t'(operation);
			idx_s1 <= entry_index;
			val_s1 <= value;
			err_s1 <= (operation == asfa_pkg::OP_POINT) && (EW'(entry_index) >= eff_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= asfa_pkg::COUNT_RESET;
			fill_value_q <= '0;
			sum_q        <= '0;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			s1_valid_s1  <= 1'b0;
		end else begin
			if (element_count_we) begin
				count_q <= element_count_wdata;
			end
			s1_valid_s1 <= accept;
			if (s1_valid_s1) begin
				sum_q       <= next_sum;
				err_q       <= err_s1;
				out_valid_q <= 1'b1;
				if (op_s1 == asfa_pkg::OP_FILL) begin
					fill_value_q <= val_s1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign total_sum   = sum_q;
	assign index_error = err_q;

`ifndef SYNTHESIS
	a_s1_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> !out_valid_q)
		else $error("update stage active while result still held");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !store_busy)
		else $error("transfer accepted during memory sweep");

	a_fill_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |=> !index_error)
		else $error("fill flagged an index error");

	a_error_keeps_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && err_s1) |=> $stable(sum_q))
		else $error("rejected point write changed the sum");
`endif

endmodule

// ===== design/asfa_store.sv =====
// Entry memory with epoch tags and sweep that retires stale tags.
module asfa_store #(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  asfa_pkg::store_cmd_t       cmd,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [VALUE_BITS-1:0]      wr_data,
	output logic [VALUE_BITS-1:0]      rd_data,
	output logic                       rd_fresh,
	output logic                       busy
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam logic [asfa_pkg::EPOCH_W-1:0] EPOCH_FIRST = asfa_pkg::EPOCH_W'(1);
	localparam logic [asfa_pkg::EPOCH_W-1:0] EPOCH_LAST  = '1;

	typedef struct packed {
		logic [asfa_pkg::EPOCH_W-1:0] tag;
		logic [VALUE_BITS-1:0]        data;
	} mem_word_t;

	mem_word_t                    mem [DEPTH];
	mem_word_t                    rd_word_s1;
	logic [asfa_pkg::EPOCH_W-1:0] epoch_q;
	logic                         clr_q;
	logic [IDX_W-1:0]             clr_addr_q;

	// tag zero never matches a live epoch
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.wr_en) begin
			mem[wr_addr] <= '{tag: epoch_q, data: wr_data};
		end
		if (cmd.rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= EPOCH_FIRST;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == IDX_W'(DEPTH - 1)) begin
				clr_q   <= 1'b0;
				epoch_q <= EPOCH_FIRST;
			end
		end else if (cmd.fill) begin
			if (epoch_q == EPOCH_LAST) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
			end else begin
				epoch_q <= epoch_q + asfa_pkg::EPOCH_W'(1);
			end
		end
	end

	assign rd_data  = rd_word_s1.data;
	assign rd_fresh = (rd_word_s1.tag == epoch_q);
	assign busy     = clr_q;

endmodule

// ===== test/running_sum_checker.sv =====
// Watches the item and result transfers, predicts the running sum and compares.
module running_sum_checker #(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          element_count_we,
	input  logic [asfa_pkg::COUNT_W-1:0]  element_count_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          operation,
	input  logic [$clog2(DEPTH)-1:0]      entry_index,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [asfa_pkg::SUM_W-1:0]    total_sum,
	input  logic                          index_error,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDX_W = $clog2(DEPTH);

	typedef struct packed {
		logic [asfa_pkg::SUM_W-1:0] sum;
		logic                       err;
	} sum_reply_t;

	sum_reply_t                   replies_due[$];
	logic [VALUE_BITS-1:0]        word_model[DEPTH];
	bit                           fresh_model[DEPTH];
	logic [VALUE_BITS-1:0]        fill_model;
	logic [asfa_pkg::SUM_W-1:0]   sum_model;
	logic [asfa_pkg::COUNT_W-1:0] count_model;
	int                           mismatches;

	function automatic int unsigned live_entries();
		return (count_model > DEPTH) ? DEPTH : int'(count_model);
	endfunction

	task automatic apply_item(asfa_pkg::op_t op, logic [IDX_W-1:0] idx,
			logic [VALUE_BITS-1:0] val);
		sum_reply_t            r;
		logic [VALUE_BITS-1:0] old;
		logic [63:0]           prod;
		r.err = 1'b0;
		if (op == asfa_pkg::OP_FILL) begin
			foreach (fresh_model[i]) fresh_model[i] = 1'b0;
			fill_model = val;
			prod = 64'(val) * 64'(live_entries());
			sum_model = prod[asfa_pkg::SUM_W-1:0];
		end else if (idx >= live_entries()) begin
			r.err = 1'b1;
		end else begin
			old = fresh_model[idx] ? word_model[idx] : fill_model;
			sum_model = sum_model - asfa_pkg::SUM_W'(old) + asfa_pkg::SUM_W'(val);
			word_model[idx] = val;
			fresh_model[idx] = 1'b1;
		end
		r.sum = sum_model;
		replies_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sum_reply_t exp;
		if (!arst_n) begin
			foreach (fresh_model[i]) fresh_model[i] = 1'b0;
			fill_model = '0;
			sum_model = '0;
			count_model = asfa_pkg::COUNT_RESET;
			replies_due.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (element_count_we)
				count_model = element_count_wdata;
			if (in_valid && in_ready)
				apply_item(asfa_pkg::op_t'(operation), entry_index, value);
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result with no item outstanding: total_sum=%0d index_error=%0b",
						total_sum, index_error);
					mismatches++;
				end else begin
					exp = replies_due.pop_front();
					if (total_sum !== exp.sum) begin
						$error("total_sum expected %0d actual %0d", exp.sum, total_sum);
						mismatches++;
					end
					if (index_error !== exp.err) begin
						$error("index_error expected %0b actual %0b", exp.err, index_error);
						mismatches++;
					end
				end
			end
			fail_count <= mismatches;
			pending <= replies_due.size();
		end
	end

endmodule

// ===== test/array_sum_point_and_fill_assign_unit_test.sv =====
// Stimulus and verdict for the array sum point/fill unit.
module array_sum_point_and_fill_assign_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH       = 1024;
	localparam int unsigned VALUE_BITS  = 32;
	localparam int unsigned IDX_W       = $clog2(DEPTH);
	localparam int          STALL_LIMIT = 20000;
	localparam int          PHASE_ITEMS = 210;

	logic                         clk;
	logic                         arst_n;
	logic                         element_count_we;
	logic [asfa_pkg::COUNT_W-1:0] element_count_wdata;
	logic                         in_valid;
	logic                         in_ready;
	logic                         operation;
	logic [IDX_W-1:0]             entry_index;
	logic [VALUE_BITS-1:0]        value;
	logic                         out_valid;
	logic                         out_ready;
	logic [asfa_pkg::SUM_W-1:0]   total_sum;
	logic                         index_error;
	int                           fail_count;
	int                           pending;

	int                           idle_pct = 17;
	int unsigned                  cur_count;
	logic [IDX_W-1:0]             last_idx;
	int                           stall_cycles;

	array_sum_point_and_fill_assign_unit #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.element_count_we(element_count_we),
		.element_count_wdata(element_count_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.entry_index(entry_index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_sum(total_sum),
		.index_error(index_error)
	);

	running_sum_checker #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) sum_check (
		.clk(clk),
		.arst_n(arst_n),
		.element_count_we(element_count_we),
		.element_count_wdata(element_count_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.entry_index(entry_index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_sum(total_sum),
		.index_error(index_error),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(asfa_pkg::op_t op, logic [IDX_W-1:0] idx,
			logic [VALUE_BITS-1:0] val);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == asfa_pkg::OP_POINT)
			last_idx = idx;
	endtask

	// hold the input until every outstanding result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_count(int unsigned c);
		drain();
		element_count_we <= 1'b1;
		element_count_wdata <= c[asfa_pkg::COUNT_W-1:0];
		@(posedge clk);
		element_count_we <= 1'b0;
		cur_count = c;
	endtask

	task automatic random_item();
		int unsigned           live;
		int unsigned           pick;
		logic [IDX_W-1:0]      idx;
		logic [VALUE_BITS-1:0] val;
		live = (cur_count > DEPTH) ? DEPTH : cur_count;
		case ($urandom_range(7))
			0:       val = '0;
			1:       val = '1;
			2:       val = VALUE_BITS'($urandom_range(15));
			default: val = $urandom();
		endcase
		pick = $urandom_range(99);
		if (pick < 10 || live == 0)
			idx = IDX_W'($urandom_range(DEPTH - 1));
		else if (pick < 25)
			idx = last_idx;
		else
			idx = IDX_W'($urandom_range(live - 1));
		if ($urandom_range(3) == 0)
			send_item(asfa_pkg::OP_FILL, IDX_W'($urandom()), val);
		else
			send_item(asfa_pkg::OP_POINT, idx, val);
	endtask

	initial begin
		int unsigned phase_counts[8];
		arst_n = 1'b0;
		element_count_we = 1'b0;
		element_count_wdata = '0;
		in_valid = 1'b0;
		operation = asfa_pkg::OP_POINT;
		entry_index = '0;
		value = '0;
		out_ready = 1'b0;
		cur_count = 32'(asfa_pkg::COUNT_RESET);
		last_idx = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, fresh and stale entries, count corners
		send_item(asfa_pkg::OP_POINT, 10'd0, 32'h0000_0000);
		send_item(asfa_pkg::OP_POINT, 10'd1023, 32'hFFFF_FFFF);
		send_item(asfa_pkg::OP_POINT, 10'd512, 32'h5555_5555);
		send_item(asfa_pkg::OP_POINT, 10'd512, 32'hAAAA_AAAA);
		send_item(asfa_pkg::OP_FILL, 10'd0, 32'hFFFF_FFFF);
		send_item(asfa_pkg::OP_POINT, 10'd5, 32'h0000_0001);
		send_item(asfa_pkg::OP_POINT, 10'd5, 32'h0000_0002);
		send_item(asfa_pkg::OP_FILL, 10'h3FF, 32'h0000_0000);
		send_item(asfa_pkg::OP_FILL, 10'd0, 32'hAAAA_AAAA);
		send_item(asfa_pkg::OP_POINT, 10'd1023, 32'h0000_0000);
		set_count(1);
		send_item(asfa_pkg::OP_POINT, 10'd0, 32'h1234_5678);
		send_item(asfa_pkg::OP_POINT, 10'd1, 32'hFFFF_FFFF);
		send_item(asfa_pkg::OP_POINT, 10'd1023, 32'hFFFF_FFFF);
		send_item(asfa_pkg::OP_FILL, 10'd0, 32'hFFFF_FFFF);
		set_count(0);
		send_item(asfa_pkg::OP_POINT, 10'd0, 32'hFFFF_FFFF);
		send_item(asfa_pkg::OP_FILL, 10'd0, 32'h0000_0005);
		set_count(2047);
		send_item(asfa_pkg::OP_POINT, 10'd1023, 32'h8000_0000);
		send_item(asfa_pkg::OP_FILL, 10'd0, 32'h0000_0001);
		send_item(asfa_pkg::OP_POINT, 10'd0, 32'hFFFF_FFFF);
		set_count(3);
		send_item(asfa_pkg::OP_POINT, 10'd2, 32'h0000_0007);
		send_item(asfa_pkg::OP_POINT, 10'd3, 32'h0000_0007);
		send_item(asfa_pkg::OP_FILL, 10'd0, 32'hFFFF_FFFF);

		phase_counts = '{1024, 2047, 1, 2, 16, 0, 1000, 3};
		phase_counts[6] = $urandom_range(2047);
		foreach (phase_counts[p]) begin
			set_count(phase_counts[p]);
			idle_pct = (p == 3) ? 0 : 17;
			repeat (PHASE_ITEMS) random_item();
		end
		idle_pct = 17;

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
